@@ src/pfgm_pkg.sv @@
// shared types, codes and sample unpacking for the pcm format gain mixer
package pfgm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 17;

	localparam logic [2:0] FMT_MONO8    = 3'd0;
	localparam logic [2:0] FMT_STEREO8  = 3'd1;
	localparam logic [2:0] FMT_MONO16   = 3'd2;
	localparam logic [2:0] FMT_STEREO16 = 3'd3;

	localparam logic REG_MASTER_GAIN = 1'b0;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} stereo_t;

	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
		logic acc;
		logic clr;
	} lane_ctrl_t;

	// unsigned byte, offset removed, scaled by 64
	function automatic logic signed [SAMPLE_W-1:0] from_byte(input logic [7:0] b);
		from_byte = {{2{~b[7]}}, ~b[7], b[6:0], 6'b0};
	endfunction

	function automatic stereo_t unpack(input logic [2:0] fmt, input logic [31:0] word);
		stereo_t s;
		s.left  = '0;
		s.right = '0;
		unique case (fmt)
			FMT_MONO8: begin
				s.left  = from_byte(word[7:0]);
				s.right = from_byte(word[7:0]);
			end
			FMT_STEREO8: begin
				s.left  = from_byte(word[7:0]);
				s.right = from_byte(word[15:8]);
			end
			FMT_MONO16: begin
				s.left  = word[15:0];
				s.right = word[15:0];
			end
			FMT_STEREO16: begin
				s.left  = word[15:0];
				s.right = word[31:16];
			end
			default: begin
				s.left  = '0;
				s.right = '0;
			end
		endcase
		unpack = s;
	endfunction

endpackage

@@ src/pcm_format_gain_mixer.sv @@
// top level of the pcm format gain mixer
// Each accepted word is one source's share of a stereo frame: the sample is
// expanded to 16-bit left/right, scaled by the source gain and the master
// gain in two registered multiplies, and added into saturating 16-bit sums
// in a left and a right lane. A word marked last_source loads the mixed frame
// into the output register and clears the sums. One word is in flight at a
// time and goes through unpack, two multiply stages and accumulate before a
// new word is taken; the closing accumulate of a last word waits while an
// earlier frame still sits unread in the output register, and the input
// stays stalled until it goes through. master_gain lies at address 0;
// writes whose low GAIN_W bits exceed 1.0 are dropped.
module pcm_format_gain_mixer #(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [2:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 active,
	input  logic [2:0]                           sample_format,
	input  logic [31:0]                          sample_word,
	input  logic [pfgm_pkg::GAIN_W-1:0]          source_gain,
	input  logic                                 last_source,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pfgm_pkg::SAMPLE_W-1:0] mixed_left,
	output logic signed [pfgm_pkg::SAMPLE_W-1:0] mixed_right,
	output logic                                 clipped
);
	import pfgm_pkg::*;

	localparam int MGW = (GAIN_FRAC_BITS + 1 > GAIN_W) ? GAIN_FRAC_BITS + 1 : GAIN_W;
	localparam logic [MGW:0] GAIN_ONE = (MGW+1)'(1) << GAIN_FRAC_BITS;

	logic [MGW-1:0]    mgain_q;
	logic              v_s1, v_s2, v_s3;
	logic              last_s1, last_s2, last_s3;
	logic [GAIN_W-1:0] sg_s1;
	logic              in_acc;
	logic              wr_en;
	stereo_t           smp;
	lane_ctrl_t        ctrl;
	logic signed [SAMPLE_W-1:0] sum_l, sum_r;
	logic              clip_l, clip_r;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_MASTER_GAIN);
	assign prdata = (paddr[2] == REG_MASTER_GAIN) ? 32'(mgain_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mgain_q <= GAIN_ONE[MGW-1:0];
		end else if (wr_en && ((MGW+1)'(pwdata[GAIN_W-1:0]) <= GAIN_ONE)) begin
			mgain_q <= MGW'(pwdata[GAIN_W-1:0]);
		end
	end

	assign in_stall = v_s1 | v_s2 | v_s3;
	assign in_acc   = in_valid & ~in_stall;

	always_comb begin
		smp = unpack(sample_format, sample_word);
		if (!active) begin
			smp = '0;
		end
	end

	always_comb begin
		ctrl.ld1 = in_acc;
		ctrl.ld2 = v_s1;
		ctrl.ld3 = v_s2;
		ctrl.acc = v_s3 & ~(last_s3 & out_valid & out_stall);
		ctrl.clr = last_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			if (v_s2) begin
				v_s3 <= 1'b1;
			end else if (ctrl.acc) begin
				v_s3 <= 1'b0;
			end
			if (in_acc) begin
				last_s1 <= last_source;
			end
			last_s2 <= last_s1;
			if (v_s2) begin
				last_s3 <= last_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sg_s1 <= source_gain;
		end
	end

	pfgm_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS), .MGW(MGW)) u_lane_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sample   (smp.left),
		.src_gain (sg_s1),
		.mst_gain (mgain_q),
		.sum_nxt  (sum_l),
		.clip_nxt (clip_l)
	);

	pfgm_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS), .MGW(MGW)) u_lane_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.sample   (smp.right),
		.src_gain (sg_s1),
		.mst_gain (mgain_q),
		.sum_nxt  (sum_r),
		.clip_nxt (clip_r)
	);

	pfgm_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.emit        (ctrl.acc & ctrl.clr),
		.left        (sum_l),
		.right       (sum_r),
		.clip_l      (clip_l),
		.clip_r      (clip_r),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.mixed_left  (mixed_left),
		.mixed_right (mixed_right),
		.clipped     (clipped)
	);

endmodule

@@ src/pfgm_lane.sv @@
// one channel lane: sign-magnitude gain multiply and saturating frame accumulator
module pfgm_lane #(
	parameter int GAIN_FRAC_BITS = 16,
	parameter int MGW            = 17
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pfgm_pkg::lane_ctrl_t                   ctrl,
	input  logic signed [pfgm_pkg::SAMPLE_W-1:0]   sample,
	input  logic        [pfgm_pkg::GAIN_W-1:0]     src_gain,
	input  logic        [MGW-1:0]                  mst_gain,
	output logic signed [pfgm_pkg::SAMPLE_W-1:0]   sum_nxt,
	output logic                                   clip_nxt
);
	import pfgm_pkg::*;

	localparam int P1W = SAMPLE_W + GAIN_W;
	localparam int P2W = P1W + MGW;
	localparam int SH  = 2 * GAIN_FRAC_BITS;
	localparam int QW  = P2W - SH;
	localparam int AW  = (QW + 2 > SAMPLE_W + 1) ? QW + 2 : SAMPLE_W + 1;
	localparam logic signed [AW-1:0] SMAX = AW'(32767);
	localparam logic signed [AW-1:0] SMIN = ~SMAX;

	logic [SAMPLE_W-1:0]       mag_s1;
	logic                      neg_s1, neg_s2, neg_s3;
	logic [P1W-1:0]            p1_s2;
	logic [P2W-1:0]            p2_s3;
	logic signed [SAMPLE_W-1:0] sum_q;
	logic                      clip_q;

	logic [QW-1:0]             q_v;
	logic signed [AW-1:0]      add_v;
	logic signed [AW-1:0]      tot_v;

	always_ff @(posedge clk) begin
		if (ctrl.ld1) begin
			neg_s1 <= sample[SAMPLE_W-1];
			mag_s1 <= sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : sample;
		end
		if (ctrl.ld2) begin
			neg_s2 <= neg_s1;
			p1_s2  <= P1W'(mag_s1) * P1W'(src_gain);
		end
		if (ctrl.ld3) begin
			neg_s3 <= neg_s2;
			p2_s3  <= P2W'(p1_s2) * P2W'(mst_gain);
		end
	end

	always_comb begin
		q_v   = p2_s3[P2W-1:SH];
		add_v = $signed({{(AW-QW){1'b0}}, q_v});
		if (neg_s3) begin
			add_v = -add_v;
		end
		tot_v    = add_v + {{(AW-SAMPLE_W){sum_q[SAMPLE_W-1]}}, sum_q};
		clip_nxt = clip_q;
		if (tot_v > SMAX) begin
			sum_nxt  = SMAX[SAMPLE_W-1:0];
			clip_nxt = 1'b1;
		end else if (tot_v < SMIN) begin
			sum_nxt  = SMIN[SAMPLE_W-1:0];
			clip_nxt = 1'b1;
		end else begin
			sum_nxt = tot_v[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			clip_q <= 1'b0;
		end else if (ctrl.acc) begin
			if (ctrl.clr) begin
				sum_q  <= '0;
				clip_q <= 1'b0;
			end else begin
				sum_q  <= sum_nxt;
				clip_q <= clip_nxt;
			end
		end
	end

endmodule

@@ src/pfgm_merge.sv @@
// frame merge stage: joins both lanes into the output word register
module pfgm_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 emit,
	input  logic signed [pfgm_pkg::SAMPLE_W-1:0] left,
	input  logic signed [pfgm_pkg::SAMPLE_W-1:0] right,
	input  logic                                 clip_l,
	input  logic                                 clip_r,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic signed [pfgm_pkg::SAMPLE_W-1:0] mixed_left,
	output logic signed [pfgm_pkg::SAMPLE_W-1:0] mixed_right,
	output logic                                 clipped
);
	import pfgm_pkg::*;

	logic                       valid_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic                       clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			left_q  <= left;
			right_q <= right;
			clip_q  <= clip_l | clip_r;
		end
	end

	assign out_valid   = valid_q;
	assign mixed_left  = left_q;
	assign mixed_right = right_q;
	assign clipped     = clip_q;

endmodule

@@ src/pfgm_checker.sv @@
// port-level assertions for the pcm format gain mixer, bound to the top level
module pfgm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_source,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] mixed_left,
	input logic [15:0] mixed_right,
	input logic        clipped
);

	// one word in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("word accepted while previous still in flight");

	// a last word produces a frame after the pipeline latency
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_source && !out_valid |-> ##4 out_valid)
		else $error("frame missing after last source word");

	// a non-last word produces no frame
	a_mid_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_source |-> ##4 !$rose(out_valid))
		else $error("frame emitted for a non-last word");

	// a new frame only comes out of a busy pipeline
	a_frame_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("frame appeared with no word in flight");

	// held output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(mixed_left) && $stable(mixed_right) && $stable(clipped))
		else $error("stalled output word changed");

endmodule

bind pcm_format_gain_mixer pfgm_checker u_pfgm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.last_source (last_source),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.mixed_left  (mixed_left),
	.mixed_right (mixed_right),
	.clipped     (clipped)
);

@@ bench/pcm_format_gain_mixer_tb.sv @@
// self-checking testbench for the pcm format gain mixer, with a frame scoreboard
`timescale 1ns / 1ps

module pcm_format_gain_mixer_tb;
	import pfgm_pkg::*;

	localparam int GAIN_FRAC = 16;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;
	localparam logic [2:0] ADDR_MASTER_GAIN = {REG_MASTER_GAIN, 2'b00};
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	localparam logic [2:0] FMT_SILENT = 3'd4;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic clip;
	} mix_frame_t;

	class frame_scoreboard;
		logic [GAIN_W-1:0] master_gain;
		int left_acc;
		int right_acc;
		bit clip_acc;
		mix_frame_t frames_due[$];
		int words_in;
		int frames_out;
		int clipped_frames;
		int mismatches;

		function new();
			master_gain = GAIN_ONE;
			left_acc = 0;
			right_acc = 0;
			clip_acc = 0;
			words_in = 0;
			frames_out = 0;
			clipped_frames = 0;
			mismatches = 0;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch at %0t: %s", $time, what);
			end
		endfunction

		function int unsigned pending();
			return frames_due.size();
		endfunction

		function void write_gain(logic [2:0] addr, logic [31:0] data);
			if (addr == ADDR_MASTER_GAIN && data[GAIN_W-1:0] <= GAIN_ONE) begin
				master_gain = data[GAIN_W-1:0];
			end
		endfunction

		function void check_gain(logic [31:0] rd);
			if (rd !== 32'(master_gain)) begin
				flag($sformatf("master_gain read %0d, expected %0d", rd, master_gain));
			end
		endfunction

		function int byte_level(logic [7:0] b);
			return (int'(b) - 128) * 64;
		endfunction

		function longint scaled(int s, logic [GAIN_W-1:0] sg);
			longint unsigned mag;
			longint unsigned prod;
			mag = (s < 0) ? longint'(-s) : longint'(s);
			prod = (mag * longint'(sg) * longint'(master_gain)) >> (2 * GAIN_FRAC);
			return (s < 0) ? -longint'(prod) : longint'(prod);
		endfunction

		function int add_sat(int sum, longint add);
			longint t;
			t = longint'(sum) + add;
			if (t > 32767) begin
				clip_acc = 1;
				return 32767;
			end
			if (t < -32768) begin
				clip_acc = 1;
				return -32768;
			end
			return int'(t);
		endfunction

		function void note_word(bit act, logic [2:0] fmt, logic [31:0] word,
				logic [GAIN_W-1:0] sg, bit last);
			int l;
			int r;
			bit audible;
			mix_frame_t f;
			l = 0;
			r = 0;
			audible = act;
			case (fmt)
				FMT_MONO8: begin
					l = byte_level(word[7:0]);
					r = l;
				end
				FMT_STEREO8: begin
					l = byte_level(word[7:0]);
					r = byte_level(word[15:8]);
				end
				FMT_MONO16: begin
					l = int'($signed(word[15:0]));
					r = l;
				end
				FMT_STEREO16: begin
					l = int'($signed(word[15:0]));
					r = int'($signed(word[31:16]));
				end
				default: audible = 0;
			endcase
			words_in++;
			if (audible) begin
				left_acc = add_sat(left_acc, scaled(l, sg));
				right_acc = add_sat(right_acc, scaled(r, sg));
			end
			if (last) begin
				f.left = SAMPLE_W'(left_acc);
				f.right = SAMPLE_W'(right_acc);
				f.clip = clip_acc;
				frames_due = {frames_due, f};
				if (clip_acc) clipped_frames++;
				left_acc = 0;
				right_acc = 0;
				clip_acc = 0;
			end
		endfunction

		function void check_frame(logic signed [SAMPLE_W-1:0] l,
				logic signed [SAMPLE_W-1:0] r, logic c);
			mix_frame_t e;
			frames_out++;
			if (frames_due.size() == 0) begin
				flag($sformatf("frame %0d/%0d clip %0b with none expected", l, r, c));
				return;
			end
			e = frames_due.pop_front();
			if (l !== e.left || r !== e.right || c !== e.clip) begin
				flag($sformatf("frame got %0d/%0d clip %0b, expected %0d/%0d clip %0b",
					l, r, c, e.left, e.right, e.clip));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic active;
	logic [2:0] sample_format;
	logic [31:0] sample_word;
	logic [GAIN_W-1:0] source_gain;
	logic last_source;
	logic out_valid;
	logic out_stall;
	logic signed [SAMPLE_W-1:0] mixed_left;
	logic signed [SAMPLE_W-1:0] mixed_right;
	logic clipped;

	frame_scoreboard sb = new();
	bit src_calm;
	bit sink_calm;
	bit hold_request;

	pcm_format_gain_mixer #(
		.GAIN_FRAC_BITS(GAIN_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.active(active),
		.sample_format(sample_format),
		.sample_word(sample_word),
		.source_gain(source_gain),
		.last_source(last_source),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mixed_left(mixed_left),
		.mixed_right(mixed_right),
		.clipped(clipped)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#20000000;
		$display("[pcm_format_gain_mixer] ERROR");
		$finish;
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		int r;
		stall_left = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && hold_left == 0) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (sink_calm) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_stall <= 1'b0;
				end else begin
					if (r < 90) stall_left = $urandom_range(0, 2);
					else if (r < 98) stall_left = $urandom_range(3, 11);
					else stall_left = $urandom_range(29, 59);
					out_stall <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_frame(mixed_left, mixed_right, clipped);
		end
	end

	function automatic int pick_gap();
		int r;
		if (src_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// called at a falling edge; returns at a falling edge after the gap
	task automatic send_word(bit act, logic [2:0] fmt, logic [31:0] word,
			logic [GAIN_W-1:0] sg, bit last);
		int g;
		in_valid <= 1'b1;
		active <= act;
		sample_format <= fmt;
		sample_word <= word;
		source_gain <= sg;
		last_source <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_word(act, fmt, word, sg, last);
		@(negedge clk);
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_gain(addr, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic gain_readback();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_MASTER_GAIN;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.check_gain(prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF;
			1: return 32'h0000_0000;
			2: return 32'h8000_8000;
			3: return 32'h7FFF_7FFF;
			4: return {16'($urandom()), 8'hFF, 8'h00};
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return GAIN_ONE;
			1: return GAIN_W'($urandom_range(0, 131071));
			2: return GAIN_W'($urandom_range(0, 8191));
			3: return GAIN_W'($urandom_range(49152, 65536));
			4: return GAIN_W'($urandom_range(65536, 131071));
			default: return GAIN_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [2:0] pick_format();
		int r;
		r = $urandom_range(0, 19);
		if (r < 18) return 3'(r % 4);
		return 3'($urandom_range(4, 7));
	endfunction

	// mostly whole frames of a few sources; a tenth carry a random last flag
	task automatic run_random(int count);
		int sent;
		int n;
		bit noisy;
		sent = 0;
		while (sent < count) begin
			n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
			noisy = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < n; i++) begin
				send_word($urandom_range(0, 9) != 0, pick_format(), pick_sample(),
					pick_gain(), noisy ? 1'($urandom_range(0, 1)) : (i == n - 1));
			end
			sent += n;
			if (sent >= count / 2 && sent - n < count / 2) begin
				wait_drained();
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		active = 1'b0;
		sample_format = FMT_MONO8;
		sample_word = '0;
		source_gain = '0;
		last_source = 1'b0;
		src_calm = 0;
		sink_calm = 0;
		hold_request = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		gain_readback();

		// byte extremes, halfword extremes, silence, inactive, hot gains
		send_word(1, FMT_MONO8, 32'hFFFF_FF00, GAIN_ONE, 1);
		send_word(1, FMT_MONO8, 32'h0000_00FF, GAIN_ONE, 1);
		send_word(1, FMT_STEREO8, 32'h0000_FF00, GAIN_ONE, 1);
		send_word(1, FMT_STEREO8, 32'hFFFF_0080, GAIN_ONE, 1);
		send_word(1, FMT_MONO16, 32'h0000_8000, GAIN_ONE, 1);
		send_word(1, FMT_STEREO16, 32'h7FFF_8000, GAIN_ONE, 1);
		send_word(1, FMT_SILENT, 32'h7FFF_7FFF, GAIN_ONE, 0);
		send_word(1, 3'd5, 32'hFFFF_FFFF, 17'h1FFFF, 0);
		send_word(1, 3'd6, 32'h8000_8000, GAIN_ONE, 0);
		send_word(1, 3'd7, 32'h7FFF_7FFF, GAIN_ONE, 1);
		send_word(0, FMT_STEREO16, 32'h7FFF_7FFF, 17'h1FFFF, 1);
		send_word(1, FMT_MONO16, 32'h0000_7FFF, 17'h1FFFF, 0);
		send_word(1, FMT_MONO16, 32'h0000_7FFF, 17'h1FFFF, 1);
		send_word(1, FMT_STEREO16, 32'h8000_8000, 17'h1FFFF, 0);
		send_word(1, FMT_STEREO16, 32'h8001_8000, 17'h1FFFF, 1);
		send_word(1, FMT_STEREO16, 32'h8000_7FFF, 17'h00000, 1);
		send_word(1, FMT_MONO8, 32'h0000_0080, GAIN_ONE, 0);
		send_word(1, FMT_STEREO8, 32'h0000_40C0, 17'h08000, 0);
		send_word(1, FMT_MONO16, 32'h0000_FFFF, 17'h00001, 0);
		send_word(0, FMT_STEREO16, 32'h1234_5678, GAIN_ONE, 0);
		send_word(1, FMT_STEREO16, 32'hC000_4000, 17'h0C000, 1);
		wait_drained();

		reg_write(ADDR_MASTER_GAIN, 32'd0);
		reg_write(ADDR_UNUSED, 32'd12345);
		gain_readback();
		run_random(250);

		reg_write(ADDR_MASTER_GAIN, 32'(GAIN_ONE));
		reg_write(ADDR_MASTER_GAIN, 32'(GAIN_ONE) + 32'd1);
		reg_write(ADDR_MASTER_GAIN, 32'h0001_FFFF);
		gain_readback();
		src_calm = 1;
		hold_request = 1;
		run_random(400);
		src_calm = 0;

		reg_write(ADDR_MASTER_GAIN, 32'hFFFE_0000 | 32'd40000);
		gain_readback();
		run_random(300);

		reg_write(ADDR_MASTER_GAIN, 32'd1);
		gain_readback();
		run_random(200);

		reg_write(ADDR_MASTER_GAIN, 32'($urandom_range(0, 65536)));
		gain_readback();
		sink_calm = 1;
		run_random(400);
		sink_calm = 0;

		reg_write(ADDR_MASTER_GAIN, 32'd32768);
		gain_readback();
		run_random(450);

		$display("mixed %0d source words into %0d frames, %0d of them clipped",
			sb.words_in, sb.frames_out, sb.clipped_frames);
		$display("master gain at zero, one step, half and full scale; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[pcm_format_gain_mixer] OK");
		end else begin
			$display("[pcm_format_gain_mixer] ERROR");
		end
		$finish;
	end

endmodule
